FILE: hw/rtl/swm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sliding window maximum block.
// No dependencies.
package swm_pkg;

    // Width of the window size register.
    localparam int CFG_BITS = 7;

    // Sequencer states.
    typedef enum logic [0:0] {
        ST_IDLE,
        ST_WORK
    } t_state;

endpackage

FILE: hw/rtl/swm_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies; read during write returns the old contents.
module swm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [WIDTH-1:0]           i_wdata,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [WIDTH-1:0]           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/swm_store.sv
`timescale 1ns / 1ps
// Deque entry storage: two mirrored RAMs, one read port for the head and one
// for the back entry, with write-to-read forwarding. Depends on swm_ram.
module swm_store #(
    parameter int DATA_W = 23,
    parameter int DEPTH  = 64
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [DATA_W-1:0]          i_wdata,
    input  logic [$clog2(DEPTH)-1:0]   i_head_addr,
    input  logic [$clog2(DEPTH)-1:0]   i_back_addr,
    output logic [DATA_W-1:0]          o_head_data,
    output logic [DATA_W-1:0]          o_back_data
);

    logic [DATA_W-1:0] head_ram;
    logic [DATA_W-1:0] back_ram;
    logic              r_head_hit;
    logic              r_back_hit;
    logic [DATA_W-1:0] r_fwd_data;

    swm_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_head_ram (
        .i_clk   (i_clk),
        .i_we    (i_we),
        .i_waddr (i_waddr),
        .i_wdata (i_wdata),
        .i_raddr (i_head_addr),
        .o_rdata (head_ram)
    );

    swm_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_back_ram (
        .i_clk   (i_clk),
        .i_we    (i_we),
        .i_waddr (i_waddr),
        .i_wdata (i_wdata),
        .i_raddr (i_back_addr),
        .o_rdata (back_ram)
    );

    // RAM returns old data on a same-address read; bypass the new entry.
    always_ff @(posedge i_clk) begin
        r_head_hit <= i_we && (i_waddr == i_head_addr);
        r_back_hit <= i_we && (i_waddr == i_back_addr);
        r_fwd_data <= i_wdata;
    end

    assign o_head_data = r_head_hit ? r_fwd_data : head_ram;
    assign o_back_data = r_back_hit ? r_fwd_data : back_ram;

endmodule

FILE: hw/rtl/sliding_window_max.sv
`timescale 1ns / 1ps
// Sliding window maximum over a signed sample stream, monotonic deque kept
// in RAM. Depends on swm_pkg and swm_store.
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+------------------------------
//  in       | input     | i_in_valid / o_in_stall    | i_sample, i_start_of_sequence
//  out      | output    | o_out_valid / i_out_stall  | o_window_max
//  cfg      | input     | i_cfg_valid / o_cfg_ready  | i_cfg_window_size
//
// Each sample is accepted, then retires P deque entries (expired at the head
// or dominated at the tail), each retire being one RAM read-compare step, and
// is then pushed. Every entry is retired at most once.
// Reset is synchronous and active low; the RAM contents need no clearing.
// A stalled output holds its result; the next sample is still taken, and the
// block only waits at the push step if that sample's result finds it full.
module sliding_window_max #(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0]     i_sample,
    input  logic                              i_start_of_sequence,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [SAMPLE_BITS-1:0]     o_window_max,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [swm_pkg::CFG_BITS-1:0]      i_cfg_window_size
);

    import swm_pkg::*;

    localparam int ADDR_W  = $clog2(MAX_WINDOW);
    localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
    localparam int POS_MOD = 2 * MAX_WINDOW;
    localparam int PW      = $clog2(POS_MOD);
    localparam int DW      = SAMPLE_BITS + PW;
    localparam int CMP_W   = (CNT_W > CFG_BITS) ? CNT_W : CFG_BITS;

    t_state                    r_state, n_state;
    logic [ADDR_W-1:0]         r_head, n_head;
    logic [ADDR_W-1:0]         r_tail, n_tail;
    logic [CNT_W-1:0]          r_count, n_count;
    logic [PW-1:0]             r_pos, n_pos;
    logic [CNT_W-1:0]          r_fill, n_fill;
    logic [CFG_BITS-1:0]       r_window_size;
    logic                      r_emit, n_emit;
    logic                      r_out_valid, n_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic signed [SAMPLE_BITS-1:0] r_out_data;

    logic                      accept;
    logic                      out_free;
    logic                      pop_head;
    logic                      pop_tail;
    logic                      push;
    logic [CNT_W-1:0]          w_eff;
    logic [CMP_W-1:0]          ws_ext;
    logic [CNT_W-1:0]          fill0;
    logic [CNT_W-1:0]          fill1;
    logic [DW-1:0]             head_data;
    logic [DW-1:0]             back_data;
    logic signed [SAMPLE_BITS-1:0] head_val;
    logic signed [SAMPLE_BITS-1:0] back_val;
    logic [PW-1:0]             head_pos;
    logic [PW:0]               age_raw;
    logic [PW-1:0]             age;
    logic [ADDR_W-1:0]         head_inc;
    logic [ADDR_W-1:0]         tail_inc;
    logic [ADDR_W-1:0]         tail_dec;
    logic [ADDR_W-1:0]         back_addr;
    logic [PW-1:0]             pos_inc;
    logic signed [SAMPLE_BITS-1:0] result;

    // ---------------- configuration ----------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= CFG_BITS'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_window_size <= i_cfg_window_size;
        end
    end

    // zero saturates to one, oversize clamps to the deque depth
    assign ws_ext = CMP_W'(r_window_size);
    always_comb begin
        if (r_window_size == '0) begin
            w_eff = CNT_W'(1);
        end else if (ws_ext > CMP_W'(MAX_WINDOW)) begin
            w_eff = CNT_W'(MAX_WINDOW);
        end else begin
            w_eff = CNT_W'(ws_ext);
        end
    end

    // ---------------- pointer arithmetic ----------------
    assign head_inc = (r_head == ADDR_W'(MAX_WINDOW - 1)) ? '0 : r_head + 1'b1;
    assign tail_inc = (r_tail == ADDR_W'(MAX_WINDOW - 1)) ? '0 : r_tail + 1'b1;
    assign tail_dec = (r_tail == '0) ? ADDR_W'(MAX_WINDOW - 1) : r_tail - 1'b1;
    assign back_addr = (n_tail == '0) ? ADDR_W'(MAX_WINDOW - 1) : n_tail - 1'b1;
    assign pos_inc  = (r_pos == PW'(POS_MOD - 1)) ? '0 : r_pos + 1'b1;

    // ---------------- entry storage ----------------
    swm_store #(.DATA_W(DW), .DEPTH(MAX_WINDOW)) u_store (
        .i_clk       (i_clk),
        .i_we        (push),
        .i_waddr     (r_tail),
        .i_wdata     ({r_sample, r_pos}),
        .i_head_addr (n_head),
        .i_back_addr (back_addr),
        .o_head_data (head_data),
        .o_back_data (back_data)
    );

    assign head_val = $signed(head_data[DW-1:PW]);
    assign head_pos = head_data[PW-1:0];
    assign back_val = $signed(back_data[DW-1:PW]);

    // age modulo 2*MAX_WINDOW
    assign age_raw = (PW+1)'(r_pos) - (PW+1)'(head_pos);
    assign age     = age_raw[PW] ? PW'(age_raw + (PW+1)'(POS_MOD)) : PW'(age_raw);

    // ---------------- sequencer ----------------
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        accept   = 1'b0;
        pop_head = 1'b0;
        pop_tail = 1'b0;
        push     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                accept = i_in_valid;
            end
            ST_WORK: begin
                if ((r_count != '0) && (age >= PW'(w_eff))) begin
                    pop_head = 1'b1;
                end else if ((r_count != '0) && (back_val <= r_sample)) begin
                    pop_tail = 1'b1;
                end else if (!r_emit || out_free) begin
                    push = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_WORK;
                end
            end
            ST_WORK: begin
                if (push) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE);

    // fill tracking is independent of the deque: settle it at accept
    assign fill0 = i_start_of_sequence ? '0 : r_fill;
    always_comb begin
        fill1 = (fill0 < w_eff) ? fill0 + 1'b1 : fill0;
        if (fill1 > w_eff) begin
            fill1 = w_eff;
        end
    end

    // with entries left after the tail pops, the head outranks the new sample
    assign result = (r_count == '0) ? r_sample : head_val;

    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_pos       = r_pos;
        n_fill      = r_fill;
        n_emit      = r_emit;
        n_out_valid = r_out_valid && i_out_stall;
        if (accept) begin
            n_fill = fill1;
            n_emit = (fill1 == w_eff);
            if (i_start_of_sequence) begin
                n_head  = '0;
                n_tail  = '0;
                n_count = '0;
                n_pos   = '0;
            end
        end
        if (pop_head) begin
            n_head  = head_inc;
            n_count = r_count - 1'b1;
        end
        if (pop_tail) begin
            n_tail  = tail_dec;
            n_count = r_count - 1'b1;
        end
        if (push) begin
            n_tail  = tail_inc;
            n_count = r_count + 1'b1;
            n_pos   = pos_inc;
            if (r_emit) begin
                n_out_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_pos       <= '0;
            r_fill      <= '0;
            r_emit      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_pos       <= n_pos;
            r_fill      <= n_fill;
            r_emit      <= n_emit;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sample <= i_sample;
        end
        if (push && r_emit) begin
            r_out_data <= result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_window_max = r_out_data;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_WINDOW))
        else $error("deque count above depth");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_head == r_tail))
        else $error("empty deque with head and tail apart");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("accepted transaction not held busy");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_window_max)))
        else $error("stalled result overwritten");
`endif

endmodule

FILE: tb/sv/tb_sliding_window_max.sv
`timescale 1ns / 1ps
// Self-checking testbench for sliding_window_max: a directed table, then random
// phases checked against a behavioral deque model. Depends on swm_pkg and the RTL.
module tb_sliding_window_max;
    import swm_pkg::*;

    localparam int MAX_WINDOW    = 64;
    localparam int SAMPLE_BITS   = 16;
    localparam int POS_BITS      = $clog2(2 * MAX_WINDOW);
    localparam int SLOT_BITS     = $clog2(MAX_WINDOW);
    localparam int GAP_MAX       = 19;
    localparam int SETTLE_CYCLES = 150;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_ITEMS  = 800;
    localparam int TIMEOUT_NS    = 5_000_000;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    typedef enum int {
        SHAPE_ANY,
        SHAPE_NARROW,
        SHAPE_FALLING,
        SHAPE_RISING,
        SHAPE_EXTREME
    } t_shape;

    typedef struct {
        bit                  is_cfg;
        logic [CFG_BITS-1:0] cfg_value;
        t_sample             smp;
        bit                  sos;
        bit                  typed;
        t_sample             typed_max;
    } t_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    t_sample             i_sample;
    logic                i_start_of_sequence;
    logic                o_out_valid;
    logic                i_out_stall;
    t_sample             o_window_max;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [CFG_BITS-1:0] i_cfg_window_size;

    // Behavioral deque state
    t_sample              cand_val [MAX_WINDOW];
    logic [POS_BITS-1:0]  cand_pos [MAX_WINDOW];
    logic [SLOT_BITS-1:0] dq_head = '0;
    logic [SLOT_BITS-1:0] dq_tail = '0;
    int                   dq_count = 0;
    logic [POS_BITS-1:0]  seq_pos = '0;
    int                   fill = 0;
    logic [CFG_BITS-1:0]  win_reg = CFG_BITS'(1);

    t_sample pending_max[$];
    int      mismatch_count = 0;
    bit      quiet = 1'b0;
    bit      hold_req = 1'b0;
    int      ramp_val = 0;

    sliding_window_max #(
        .MAX_WINDOW (MAX_WINDOW),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_sample           (i_sample),
        .i_start_of_sequence(i_start_of_sequence),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_window_max       (o_window_max),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_window_size  (i_cfg_window_size)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Register value 0 means 1, anything above MAX_WINDOW means MAX_WINDOW.
    function automatic int span_of(input logic [CFG_BITS-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_WINDOW)
            return MAX_WINDOW;
        return int'(v);
    endfunction

    function automatic bit track_window_max(input t_sample s, input bit sos,
                                            output t_sample m);
        int                   w;
        bit                   done;
        logic [POS_BITS-1:0]  age;
        logic [SLOT_BITS-1:0] back;
        w = span_of(win_reg);
        if (sos) begin
            dq_head  = '0;
            dq_tail  = '0;
            dq_count = 0;
            fill     = 0;
            seq_pos  = '0;
        end
        // expire at the head; age wraps modulo 2*MAX_WINDOW
        done = 1'b0;
        while (dq_count > 0 && !done) begin
            age = seq_pos - cand_pos[dq_head];
            if (age < w) begin
                done = 1'b1;
            end else begin
                dq_head  = dq_head + 1'b1;
                dq_count = dq_count - 1;
            end
        end
        // entries not larger than the new sample leave at the tail
        done = 1'b0;
        while (dq_count > 0 && !done) begin
            back = dq_tail - 1'b1;
            if (cand_val[back] > s) begin
                done = 1'b1;
            end else begin
                dq_tail  = back;
                dq_count = dq_count - 1;
            end
        end
        if (dq_count >= MAX_WINDOW) begin
            dq_head  = dq_head + 1'b1;
            dq_count = dq_count - 1;
        end
        cand_val[dq_tail] = s;
        cand_pos[dq_tail] = seq_pos;
        dq_tail  = dq_tail + 1'b1;
        dq_count = dq_count + 1;
        seq_pos  = seq_pos + 1'b1;
        if (fill < w)
            fill = fill + 1;
        if (fill > w)
            fill = w;
        m = cand_val[dq_head];
        return fill >= w;
    endfunction

    function automatic t_sample next_sample(input t_shape shape);
        case (shape)
            SHAPE_NARROW: begin
                return t_sample'(int'($urandom_range(0, 8)) - 4);
            end
            SHAPE_FALLING: begin
                ramp_val = ramp_val - int'($urandom_range(0, 3));
                if (ramp_val < -32768)
                    ramp_val = 32767;
                return t_sample'(ramp_val);
            end
            SHAPE_RISING: begin
                ramp_val = ramp_val + int'($urandom_range(0, 3));
                if (ramp_val > 32767)
                    ramp_val = -32768;
                return t_sample'(ramp_val);
            end
            SHAPE_EXTREME: begin
                case ($urandom_range(0, 4))
                    0: return 16'sh7FFF;
                    1: return 16'sh8000;
                    2: return 16'sh7FFE;
                    3: return 16'sh8001;
                    default: return '0;
                endcase
            end
            default: begin
                return t_sample'($urandom_range(0, 16'hFFFF));
            end
        endcase
    endfunction

    function automatic t_row make_row(input int is_cfg, input int cfg_value, input int smp,
                                      input int sos, input int typed, input int typed_max);
        t_row r;
        r.is_cfg    = (is_cfg != 0);
        r.cfg_value = cfg_value[CFG_BITS-1:0];
        r.smp       = t_sample'(smp);
        r.sos       = (sos != 0);
        r.typed     = (typed != 0);
        r.typed_max = t_sample'(typed_max);
        return r;
    endfunction

    // Drops valid, then waits until all results are in and the block has drained.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_max.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_sample(input t_sample s, input bit sos, input bit typed,
                               input t_sample typed_max);
        int      gap;
        t_sample m;
        gap = quiet ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid          <= 1'b1;
        i_sample            <= s;
        i_start_of_sequence <= sos;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        if (track_window_max(s, sos, m))
            pending_max.insert(pending_max.size(), typed ? typed_max : m);
    endtask

    task automatic write_window(input logic [CFG_BITS-1:0] v);
        settle();
        i_cfg_valid       <= 1'b1;
        i_cfg_window_size <= v;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        win_reg = v;
    endtask

    // Result check
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_max.size() == 0) begin
                $error("window_max: no result expected, actual %0d", o_window_max);
                mismatch_count++;
            end else begin
                if (o_window_max !== pending_max[0]) begin
                    $error("window_max: expected %0d, actual %0d",
                           pending_max[0], o_window_max);
                    mismatch_count++;
                end
                pending_max.delete(0);
            end
        end
    end

    // Receiver: random stall before each transaction, one long hold on request.
    initial begin
        int n;
        forever begin
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end
            n = quiet ? 0 : $urandom_range(0, GAP_MAX);
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (o_out_valid !== 1'b1)
                @(posedge i_clk);
        end
    end

    initial begin
        t_row   rows[$];
        int     sent;
        int     phase;
        int     len;
        bit     sos;
        t_shape shape;
        logic [CFG_BITS-1:0] v;

        i_rst_n             = 1'b0;
        i_in_valid          = 1'b0;
        i_sample            = '0;
        i_start_of_sequence = 1'b0;
        i_cfg_valid         = 1'b0;
        i_cfg_window_size   = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // window is 1 out of reset: each sample is its own max
        rows.insert(rows.size(), make_row(0, 0, 32767, 1, 1, 32767));
        rows.insert(rows.size(), make_row(0, 0, -32768, 0, 1, -32768));
        rows.insert(rows.size(), make_row(0, 0, 0, 0, 1, 0));
        rows.insert(rows.size(), make_row(0, 0, -1, 0, 1, -1));
        rows.insert(rows.size(), make_row(0, 0, 21845, 0, 1, 21845));
        rows.insert(rows.size(), make_row(0, 0, -21846, 0, 1, -21846));
        rows.insert(rows.size(), make_row(1, 4, 0, 0, 0, 0));
        rows.insert(rows.size(), make_row(0, 0, 10, 1, 0, 0));
        rows.insert(rows.size(), make_row(0, 0, 20, 0, 0, 0));
        rows.insert(rows.size(), make_row(0, 0, 5, 0, 0, 0));
        rows.insert(rows.size(), make_row(0, 0, 5, 0, 0, 0));
        rows.insert(rows.size(), make_row(0, 0, -3, 0, 0, 0));
        rows.insert(rows.size(), make_row(0, 0, 7, 0, 0, 0));
        rows.insert(rows.size(), make_row(0, 0, -32768, 0, 0, 0));
        // restart with a partial window, then shrink below the fill level
        rows.insert(rows.size(), make_row(0, 0, 100, 1, 0, 0));
        rows.insert(rows.size(), make_row(0, 0, 200, 0, 0, 0));
        rows.insert(rows.size(), make_row(0, 0, 150, 0, 0, 0));
        rows.insert(rows.size(), make_row(1, 2, 0, 0, 0, 0));
        rows.insert(rows.size(), make_row(0, 0, 50, 0, 0, 0));
        rows.insert(rows.size(), make_row(0, 0, -40, 0, 0, 0));
        // grow: results pause until the window fills again
        rows.insert(rows.size(), make_row(1, 6, 0, 0, 0, 0));
        rows.insert(rows.size(), make_row(0, 0, 1, 0, 0, 0));
        rows.insert(rows.size(), make_row(0, 0, 2, 0, 0, 0));
        rows.insert(rows.size(), make_row(0, 0, 3, 0, 0, 0));
        rows.insert(rows.size(), make_row(0, 0, 4, 0, 0, 0));
        // zero saturates to one
        rows.insert(rows.size(), make_row(1, 0, 0, 0, 0, 0));
        rows.insert(rows.size(), make_row(0, 0, -5, 0, 1, -5));
        // oversize saturates to MAX_WINDOW
        rows.insert(rows.size(), make_row(1, 127, 0, 0, 0, 0));
        rows.insert(rows.size(), make_row(0, 0, 9, 1, 0, 0));
        rows.insert(rows.size(), make_row(0, 0, 8, 0, 0, 0));

        foreach (rows[i]) begin
            if (rows[i].is_cfg)
                write_window(rows[i].cfg_value);
            else
                send_sample(rows[i].smp, rows[i].sos, rows[i].typed, rows[i].typed_max);
        end

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            case (phase)
                0: v = CFG_BITS'(64);
                1: v = CFG_BITS'(0);
                2: v = CFG_BITS'(127);
                3: v = CFG_BITS'(1);
                4: v = CFG_BITS'(65);
                5: v = CFG_BITS'(2);
                6: v = CFG_BITS'(63);
                default: v = CFG_BITS'($urandom_range(0, 127));
            endcase
            write_window(v);
            // phase 3: window 1, sender flat out while the receiver holds off
            quiet = (phase == 3) || ($urandom_range(0, 3) == 0);
            if (phase == 3)
                hold_req = 1'b1;
            len   = span_of(v) + $urandom_range(40, 120);
            shape = t_shape'($urandom_range(0, 4));
            ramp_val = (shape == SHAPE_FALLING) ? 32767 - int'($urandom_range(0, 200))
                                                : -32768 + int'($urandom_range(0, 200));
            for (int k = 0; k < len; k++) begin
                // a sequence continues across a window change about one time in four
                sos = (k == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 79) == 0);
                if ($urandom_range(0, 7) == 0)
                    send_sample(next_sample(SHAPE_ANY), sos, 1'b0, '0);
                else
                    send_sample(next_sample(shape), sos, 1'b0, '0);
                sent++;
            end
            phase++;
        end

        quiet = 1'b0;
        settle();
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/swm_pkg.sv
hw/rtl/swm_ram.sv
hw/rtl/swm_store.sv
hw/rtl/sliding_window_max.sv
tb/sv/tb_sliding_window_max.sv
